[hw/rtl/itd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itd_pkg: shared types and constants for the integer to text converter
// Beat types, operation and mode codes, character codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package itd_pkg;

	localparam int CHAR_BITS_DEF = 16;
	localparam int DEC_PLACES    = 10;
	localparam int HEX_PLACES    = 8;
	localparam int VALUE_BITS    = 32;

	// operation codes
	localparam logic [1:0] OP_SDEC = 2'd0;
	localparam logic [1:0] OP_UDEC = 2'd1;
	localparam logic [1:0] OP_HEX  = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	// conversion modes
	localparam logic [1:0] MODE_SIGNED = 2'd0;
	localparam logic [1:0] MODE_PADDED = 2'd1;
	localparam logic [1:0] MODE_HEX    = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	// character codes
	localparam logic [15:0] ASC_ZERO  = 16'h0030;
	localparam logic [15:0] ASC_UPA   = 16'h0041;
	localparam logic [15:0] ASC_MINUS = 16'h002D;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] value;
		logic [15:0] pad_char;
	} item_t;

	typedef struct packed {
		logic [15:0] char_out;
		logic        last;
	} text_t;

	typedef struct packed {
		logic       load;      // capture the input beat
		logic       step;      // one shift-and-add-3 iteration
		logic       put;       // write a character into the output register
		logic       put_sign;  // the character is the minus sign
		logic       last;      // the character ends the text
		logic [3:0] pos;       // digit position to emit
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       neg;
		logic [3:0] ndig;      // significant decimal digits, 1..10
		logic       out_free;
	} stat_t;

endpackage

[hw/rtl/itd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itd_ctrl: sequencer for the integer to text converter
// Accepts a beat, runs the binary to BCD iterations for decimal modes and steps
// through the character positions while the output register has room.
// ----------------------------------------------------------------------------
module itd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_stall,
	input  itd_pkg::stat_t stat,
	output itd_pkg::cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_CONV  = 3'd2;
	localparam logic [2:0] ST_PREP  = 3'd3;
	localparam logic [2:0] ST_SIGN  = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	localparam int CNT_W = $clog2(itd_pkg::VALUE_BITS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(itd_pkg::VALUE_BITS - 1);

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [3:0]       pos_q, pos_d;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		pos_d        = pos_q;
		cmd          = '0;
		cmd.pos      = pos_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				unique case (stat.mode)
					itd_pkg::MODE_NONE: state_d = ST_IDLE;
					itd_pkg::MODE_HEX: begin
						pos_d   = 4'(itd_pkg::HEX_PLACES - 1);
						state_d = ST_EMIT;
					end
					itd_pkg::MODE_SIGNED, itd_pkg::MODE_PADDED: begin
						cnt_d   = '0;
						state_d = ST_CONV;
					end
				endcase
			end
			ST_CONV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				pos_d   = (stat.mode == itd_pkg::MODE_PADDED) ?
					4'(itd_pkg::DEC_PLACES - 1) : stat.ndig - 4'd1;
				state_d = stat.neg ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: begin
				if (stat.out_free) begin
					cmd.put      = 1'b1;
					cmd.put_sign = 1'b1;
					state_d      = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.put  = 1'b1;
					cmd.last = (pos_q == 4'd0);
					if (pos_q == 4'd0) begin
						state_d = ST_IDLE;
					end else begin
						pos_d = pos_q - 4'd1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos_d;
		end
	end

endmodule

[hw/rtl/itd_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itd_dp: datapath of the integer to text converter
// Holds the operand, the BCD shift register and the output register, and
// forms each character from the digit at the position the sequencer names.
// ----------------------------------------------------------------------------
module itd_dp #(
	parameter int CHAR_BITS = itd_pkg::CHAR_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  itd_pkg::item_t item,
	input  itd_pkg::cmd_t  cmd,
	output itd_pkg::stat_t stat,
	output logic           text_valid,
	input  logic           text_stall,
	output itd_pkg::text_t text
);

	localparam logic [15:0] CHAR_MASK = 16'((32'd1 << CHAR_BITS) - 32'd1);

	logic [1:0]                                mode_q;
	logic                                      neg_q;
	logic [15:0]                               pad_q;
	logic [itd_pkg::VALUE_BITS-1:0]            sr_q;
	logic [itd_pkg::DEC_PLACES-1:0][3:0]       bcd_q;
	logic                                      out_valid_q;
	itd_pkg::text_t                            out_q;

	logic [1:0]                                mode_d;
	logic [15:0]                               pad_m;
	logic                                      neg_d;
	logic [itd_pkg::DEC_PLACES-1:0][3:0]       bcd_adj;
	logic [3:0]                                ndig;
	logic [itd_pkg::HEX_PLACES-1:0][3:0]       nibs;
	logic [3:0]                                nib;
	logic [3:0]                                dig;
	logic [15:0]                               ch;

	// decode the operation at load
	assign pad_m = item.pad_char & CHAR_MASK;
	always_comb begin
		unique case (item.op)
			itd_pkg::OP_SDEC: mode_d = itd_pkg::MODE_SIGNED;
			itd_pkg::OP_UDEC: mode_d = (pad_m == 16'd0) ? itd_pkg::MODE_SIGNED
			                                            : itd_pkg::MODE_PADDED;
			itd_pkg::OP_HEX:  mode_d = itd_pkg::MODE_HEX;
			itd_pkg::OP_RSVD: mode_d = itd_pkg::MODE_NONE;
		endcase
	end
	assign neg_d = (mode_d == itd_pkg::MODE_SIGNED) && item.value[itd_pkg::VALUE_BITS-1];

	// add 3 to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < itd_pkg::DEC_PLACES; i++) begin
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
	end

	// count significant digits, at least one
	always_comb begin
		ndig = 4'd1;
		for (int i = 0; i < itd_pkg::DEC_PLACES; i++) begin
			if (bcd_q[i] != 4'd0) begin
				ndig = 4'(i + 1);
			end
		end
	end

	assign nibs = sr_q;
	assign nib  = nibs[cmd.pos[2:0]];
	assign dig  = bcd_q[cmd.pos];

	always_comb begin
		if (cmd.put_sign) begin
			ch = itd_pkg::ASC_MINUS;
		end else if (mode_q == itd_pkg::MODE_HEX) begin
			ch = (nib < 4'd10) ? itd_pkg::ASC_ZERO + 16'(nib)
			                   : itd_pkg::ASC_UPA + 16'(nib) - 16'd10;
		end else if (mode_q == itd_pkg::MODE_PADDED && cmd.pos >= ndig) begin
			ch = pad_q;
		end else begin
			ch = itd_pkg::ASC_ZERO + 16'(dig);
		end
	end

	assign stat.mode     = mode_q;
	assign stat.neg      = neg_q;
	assign stat.ndig     = ndig;
	assign stat.out_free = !out_valid_q || !text_stall;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode_d;
			neg_q  <= neg_d;
			pad_q  <= pad_m;
			sr_q   <= neg_d ? ('0 - item.value) : item.value;
			bcd_q  <= '0;
		end else if (cmd.step) begin
			{bcd_q, sr_q} <= {bcd_adj, sr_q} << 1;
		end
		if (cmd.put) begin
			out_q.char_out <= ch & CHAR_MASK;
			out_q.last     <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put) begin
			out_valid_q <= 1'b1;
		end else if (!text_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign text_valid = out_valid_q;
	assign text       = out_q;

endmodule

[hw/rtl/integer_to_text_digits.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_text_digits: 32-bit number to decimal or hex text
// Converts one number per input beat into a string of characters.
// ----------------------------------------------------------------------------
// Usage:
//   item channel: one beat carries op, value and pad_char. It is taken when
//   item_valid is high and item_stall is low. Op 0 writes signed decimal,
//   op 1 ten-place unsigned decimal filled on the left with the pad (a pad
//   of zero writes signed decimal instead), op 2 eight uppercase hex
//   digits, op 3 produces no text.
//   text channel: one beat per character, most significant first, with
//   last set on the final character; no terminator is sent.
//   Timing: decimal text first needs the shift-and-add-3 iterations, one
//   per bit of the value, before the first character appears; hex text
//   skips them. Characters then follow one per cycle while text_stall is
//   low. The converter works on one number at a time; a new beat is
//   taken once the final character sits in the output register.
//   Stall: text_stall holds the output register and the sequencer waits;
//   no character is lost.
//   Reset: arst_n clears the sequencer and the output valid at once.
// ----------------------------------------------------------------------------
module integer_to_text_digits #(
	parameter int CHAR_BITS = itd_pkg::CHAR_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  itd_pkg::item_t item,
	output logic           text_valid,
	input  logic           text_stall,
	output itd_pkg::text_t text
);

	itd_pkg::cmd_t  cmd;
	itd_pkg::stat_t stat;

	// sequencer: accept, iterate, step through character positions
	itd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	// operand, BCD register, character forming and output register
	itd_dp #(
		.CHAR_BITS (CHAR_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cmd        (cmd),
		.stat       (stat),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text)
	);

endmodule

[tb/sv/integer_to_text_digits_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_text_digits_tb: self-checking bench for the number to text block
// Sends numbers with every operation and checks each returned character and
// its last flag against the text predicted here. Covers sign and magnitude
// extremes, pad fill and the zero-pad fallback, all hex nibbles and the
// ignored op, then several hundred random numbers with random gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module integer_to_text_digits_tb;

	localparam int IDLE_LIMIT    = 2000;  // cycles with no beat on either channel
	localparam int TAIL_CYCLES   = 60;    // one whole conversion and some spare
	localparam int RANDOM_ITEMS  = 345;

	logic           clk;
	logic           arst_n     = 1'b0;
	logic           item_valid = 1'b0;
	logic           item_stall;
	itd_pkg::item_t item       = '0;
	logic           text_valid;
	logic           text_stall = 1'b0;
	itd_pkg::text_t text;

	// characters still owed by the block, oldest first
	itd_pkg::text_t expected_text[$];
	int    mismatches  = 0;
	int    chars_seen  = 0;
	int    items_by_op[4];
	int    stuck_cycles = 0;
	bit    idling       = 1'b1;

	integer_to_text_digits i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Text predictor
	// ------------------------------------------------------------------

	function automatic void owe_char(input logic [15:0] ch, input logic fin);
		itd_pkg::text_t c;
		c.char_out = ch;
		c.last     = fin;
		expected_text.push_back(c);
	endfunction

	// Append the decimal digits of mag, most significant first; the final
	// digit ends the text. Leading places up to ten are filled with pad
	// only when fill is set.
	function automatic void owe_decimal(input logic [31:0] mag, input bit fill,
			input logic [15:0] pad);
		logic [3:0]  digs[itd_pkg::DEC_PLACES];
		logic [31:0] rest;
		int          n;
		rest = mag;
		n    = 0;
		do begin
			digs[n] = 4'(rest % 10);
			rest    = rest / 10;
			n++;
		end while (rest != 0 && n < itd_pkg::DEC_PLACES);
		if (fill)
			for (int i = 0; i < itd_pkg::DEC_PLACES - n; i++)
				owe_char(pad, 1'b0);
		for (int i = n - 1; i >= 0; i--)
			owe_char(itd_pkg::ASC_ZERO + 16'(digs[i]), i == 0);
	endfunction

	// Work out the full text of one accepted number.
	function automatic void format_number(input itd_pkg::item_t it);
		logic [3:0] nib;
		logic       neg;
		if (it.op == itd_pkg::OP_HEX) begin
			for (int k = 0; k < itd_pkg::HEX_PLACES; k++) begin
				nib = it.value[31 - 4 * k -: 4];
				owe_char(nib < 10 ? itd_pkg::ASC_ZERO + 16'(nib)
				                  : itd_pkg::ASC_UPA + 16'(nib) - 16'd10,
					k == itd_pkg::HEX_PLACES - 1);
			end
		end else if (it.op == itd_pkg::OP_SDEC ||
				(it.op == itd_pkg::OP_UDEC && it.pad_char == '0)) begin
			// a zero pad turns the padded form into signed decimal
			neg = it.value[31];
			if (neg)
				owe_char(itd_pkg::ASC_MINUS, 1'b0);
			owe_decimal(neg ? -it.value : it.value, 1'b0, '0);
		end else if (it.op == itd_pkg::OP_UDEC) begin
			owe_decimal(it.value, 1'b1, it.pad_char);
		end
		// the reserved op produces no text
	endfunction

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------

	// Gap or stall length: mostly none or short, now and then long; none when idling is clear.
	function automatic int pause_length();
		int r;
		if (!idling)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] random_value();
		logic [31:0] p;
		case ($urandom_range(0, 6))
			0: return $urandom_range(0, 20);
			1: begin
				// around a power of ten, where the digit count changes
				p = 1;
				repeat ($urandom_range(0, 9)) p = p * 10;
				return p + $urandom_range(0, 2) - 1;
			end
			2: return 32'h8000_0000 + $urandom_range(0, 3);
			3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
			4: return -$urandom_range(0, 1000);
			5: return $urandom >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] random_pad();
		case ($urandom_range(0, 5))
			0: return '0;
			1, 2: return 16'($urandom_range(16'h20, 16'h7E));
			default: return 16'($urandom_range(1, 16'hFFFF));
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Item channel
	// ------------------------------------------------------------------

	// Present one beat, hold it until taken, then predict its text. Valid
	// stays high when the next beat follows at once.
	task automatic send_number(input logic [1:0] op, input logic [31:0] value,
			input logic [15:0] pad);
		itd_pkg::item_t beat;
		int             gap;
		beat.op       = op;
		beat.value    = value;
		beat.pad_char = pad;
		item       <= beat;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		format_number(beat);
		items_by_op[op]++;
		gap = pause_length();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every owed character has come back.
	task automatic drain_text();
		item_valid <= 1'b0;
		while (expected_text.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_signed_decimal();
		send_number(itd_pkg::OP_SDEC, 32'd0, 16'h0020);
		send_number(itd_pkg::OP_SDEC, 32'd9, 16'h0020);
		send_number(itd_pkg::OP_SDEC, 32'd10, 16'h0020);
		send_number(itd_pkg::OP_SDEC, 32'hFFFF_FFFF, 16'h0020);
		send_number(itd_pkg::OP_SDEC, 32'h7FFF_FFFF, 16'h0000);
		// most negative value: magnitude written in full
		send_number(itd_pkg::OP_SDEC, 32'h8000_0000, 16'hFFFF);
		send_number(itd_pkg::OP_SDEC, 32'd1_000_000_000, 16'h0020);
	endtask

	task automatic test_padded_decimal();
		send_number(itd_pkg::OP_UDEC, 32'd0, 16'h0020);
		send_number(itd_pkg::OP_UDEC, 32'hFFFF_FFFF, 16'h002A);
		send_number(itd_pkg::OP_UDEC, 32'd42, 16'hFFFF);
		send_number(itd_pkg::OP_UDEC, 32'd999_999_999, 16'h0001);
		// zero pad falls back to signed decimal
		send_number(itd_pkg::OP_UDEC, 32'h8000_0000, 16'h0000);
		send_number(itd_pkg::OP_UDEC, 32'd5, 16'h0000);
	endtask

	task automatic test_hex();
		send_number(itd_pkg::OP_HEX, 32'h0000_0000, 16'h0020);
		send_number(itd_pkg::OP_HEX, 32'hFFFF_FFFF, 16'h0000);
		send_number(itd_pkg::OP_HEX, 32'h0123_4567, 16'h0030);
		send_number(itd_pkg::OP_HEX, 32'h89AB_CDEF, 16'hFFFF);
	endtask

	// The reserved op must be swallowed without text; real numbers follow
	// right behind to show nothing leaks out.
	task automatic test_reserved_op();
		send_number(itd_pkg::OP_RSVD, 32'hFFFF_FFFF, 16'hFFFF);
		send_number(itd_pkg::OP_SDEC, 32'd7, 16'h0020);
		send_number(itd_pkg::OP_RSVD, $urandom, 16'($urandom_range(0, 16'hFFFF)));
		send_number(itd_pkg::OP_HEX, 32'hA5A5_5A5A, 16'h0020);
	endtask

	// Let the block run dry, then start again with more beats.
	task automatic test_drain_pause();
		for (int i = 0; i < 4; i++)
			send_number(2'($urandom_range(0, 2)), random_value(), random_pad());
		drain_text();
		repeat ($urandom_range(1, 10)) @(posedge clk);
		for (int i = 0; i < 4; i++)
			send_number(2'($urandom_range(0, 2)), random_value(), random_pad());
	endtask

	// Mostly real conversions with random content, a few ignored beats,
	// and stretches with and without idling on both sides.
	task automatic test_random_mix();
		int          counted;
		logic [1:0]  op;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if (counted % 40 == 0)
				idling = ($urandom_range(0, 3) != 0);
			op = ($urandom_range(0, 99) < 5) ? itd_pkg::OP_RSVD
			                                 : 2'($urandom_range(0, 2));
			send_number(op, random_value(), random_pad());
			if (op != itd_pkg::OP_RSVD)
				counted++;
		end
		idling = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Text channel: random stall, checking and watchdog
	// ------------------------------------------------------------------

	initial begin : stall_driver
		int hold;
		forever begin
			hold = pause_length();
			if (hold != 0) begin
				text_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			text_stall <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		itd_pkg::text_t want;
		if (arst_n && text_valid && !text_stall) begin
			chars_seen++;
			if (expected_text.size() == 0) begin
				$error("unexpected character: char_out %h last %b", text.char_out, text.last);
				mismatches++;
			end else begin
				want = expected_text.pop_front();
				if (text.char_out !== want.char_out) begin
					$error("char_out: expected %h, got %h", want.char_out, text.char_out);
					mismatches++;
				end
				if (text.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, text.last);
					mismatches++;
				end
			end
		end
	end

	// End the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (text_valid && !text_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= IDLE_LIMIT) begin
			$display("timeout: no beat for %0d cycles", IDLE_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_signed_decimal();
		test_padded_decimal();
		test_hex();
		test_reserved_op();
		test_drain_pause();
		test_random_mix();

		drain_text();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Converted %0d signed, %0d padded, %0d hex numbers; ignored %0d reserved beats",
			items_by_op[itd_pkg::OP_SDEC], items_by_op[itd_pkg::OP_UDEC],
			items_by_op[itd_pkg::OP_HEX], items_by_op[itd_pkg::OP_RSVD]);
		$display("Checked %0d characters, %0d mismatches", chars_seen, mismatches);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
